FILE: src/dlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the styled DDA line rasteriser
// Holds the coordinate and fixed-point widths, the request and style codes,
// the controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dlr_pkg;

  // Geometry and fixed-point format.
  localparam int COORD_BITS  = 10;
  localparam int FRAC_BITS   = 16;
  localparam int DASH_PERIOD = 13;

  // Derived widths.
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int IDX_BITS   = COORD_BITS + 1;
  localparam int DIV_W      = COORD_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(DIV_W + 1);
  localparam int PHASE_BITS = $clog2(DASH_PERIOD);

  // Request codes.
  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_e;

  // Line styles.
  typedef enum logic [1:0] {
    STYLE_DASHED     = 2'd0,
    STYLE_DOTTED     = 2'd1,
    STYLE_SOLID      = 2'd2,
    STYLE_START_ONLY = 2'd3
  } style_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FIX  = 2'd2,
    ST_DRAW = 2'd3
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // Load a new line and emit its start pixel.
    logic advance;   // Take one DDA step and emit the pixel.
    logic idle_adv;  // Repeat the current pixel as hidden and last.
    logic div_run;   // Run one iteration of the increment dividers.
    logic div_fix;   // Apply signs and load the increments.
  } dlr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_fin; // The line being started has only its start pixel.
    logic adv_fin;   // The next step reaches the endpoint.
    logic div_done;  // The current divider iteration is the final one.
  } dlr_stat_t;

endpackage : dlr_pkg
`default_nettype wire

FILE: src/dlr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_req_if: request channel of the line rasteriser
// Valid/ready channel carrying start and advance requests.
// ----------------------------------------------------------------------------
interface dlr_req_if
  import dlr_pkg::*;
();

  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [1:0]            line_style;

  modport source (
    output valid, req_type, x_start, y_start, x_end, y_end, line_style,
    input  ready
  );

  modport sink (
    input  valid, req_type, x_start, y_start, x_end, y_end, line_style,
    output ready
  );

endinterface : dlr_req_if
`default_nettype wire

FILE: src/dlr_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_pix_if: pixel channel of the line rasteriser
// Valid/ready channel carrying one pixel with its visibility and last flag.
// ----------------------------------------------------------------------------
interface dlr_pix_if
  import dlr_pkg::*;
();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  visible;
  logic                  last;

  modport source (
    output valid, pixel_x, pixel_y, visible, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, visible, last,
    output ready
  );

endinterface : dlr_pix_if
`default_nettype wire

FILE: src/dda_line_rasterizer_styled.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_rasterizer_styled: styled fixed-point DDA line rasteriser
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as beats on req_i. A start beat carries the two endpoints
//   and a style; an advance beat asks for the next pixel. Every request gives
//   exactly one pixel beat on pix_o, with its visibility and a last flag.
//   The pixel of a request appears in the output register in the cycle after
//   the request beat is taken.
//   Advance beats are taken at one per cycle while a line is drawn and the
//   receiver keeps taking the pixel beats. After a start beat that opens a
//   real line, the block takes no request while the increments are formed:
//   two restoring dividers each produce one quotient bit a cycle, and a final
//   step applies the signs.
//   A start beat for a zero-length line or the start-pixel-only style needs
//   no division and is followed by the next request at once.
//   While the pixel register holds a beat that the receiver has not taken,
//   a new request is taken only in the cycle that beat leaves; otherwise
//   req_i.ready stays low and the held beat stays unchanged.
//   Reset clears the position to the origin and leaves the block idle.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_styled
  import dlr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dlr_req_if.sink   req_i,
  dlr_pix_if.source pix_o
);

  dlr_cmd_t  cmd;
  dlr_stat_t stat;
  logic      in_ready;
  logic      out_valid;

  // Sequencing and handshake.
  dlr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_req_type_i (req_i.req_type),
    .in_ready_o    (in_ready),
    .out_valid_o   (out_valid),
    .out_ready_i   (pix_o.ready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Arithmetic and payload storage.
  dlr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .x_start_i    (req_i.x_start),
    .y_start_i    (req_i.y_start),
    .x_end_i      (req_i.x_end),
    .y_end_i      (req_i.y_end),
    .line_style_i (req_i.line_style),
    .pixel_x_o    (pix_o.pixel_x),
    .pixel_y_o    (pix_o.pixel_y),
    .visible_o    (pix_o.visible),
    .last_o       (pix_o.last)
  );

  assign req_i.ready = in_ready;
  assign pix_o.valid = out_valid;

endmodule : dda_line_rasterizer_styled
`default_nettype wire

FILE: src/dlr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_ctrl: controller of the line rasteriser
// Sequences line starts, the increment division and the drawing steps, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module dlr_ctrl
  import dlr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_req_type_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire dlr_stat_t stat_i,
  output dlr_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state, handshake and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = ((state_q == ST_IDLE) || (state_q == ST_DRAW))
                 && (!out_valid_q || out_ready_i);
    in_fire    = in_valid_i && in_ready_o;

    cmd_o          = '0;
    cmd_o.start    = in_fire && (req_e'(in_req_type_i) == REQ_START);
    cmd_o.advance  = in_fire && (req_e'(in_req_type_i) == REQ_ADVANCE)
                     && (state_q == ST_DRAW);
    cmd_o.idle_adv = in_fire && (req_e'(in_req_type_i) == REQ_ADVANCE)
                     && (state_q == ST_IDLE);
    cmd_o.div_run  = (state_q == ST_DIV);
    cmd_o.div_fix  = (state_q == ST_FIX);

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.start && !stat_i.start_fin) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        state_d = ST_DRAW;
      end
      ST_DRAW: begin
        if (cmd_o.start) begin
          state_d = stat_i.start_fin ? ST_IDLE : ST_DIV;
        end else if (cmd_o.advance && stat_i.adv_fin) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A beat loads the output register; a taken beat empties it.
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : dlr_ctrl
`default_nettype wire

FILE: src/dlr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_dp: datapath of the line rasteriser
// Holds the fixed-point accumulators, step counters, two restoring dividers
// for the per-step increments and the output payload register.
// ----------------------------------------------------------------------------
module dlr_dp
  import dlr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dlr_cmd_t              cmd_i,
  output dlr_stat_t                  stat_o,
  input  wire logic [COORD_BITS-1:0] x_start_i,
  input  wire logic [COORD_BITS-1:0] y_start_i,
  input  wire logic [COORD_BITS-1:0] x_end_i,
  input  wire logic [COORD_BITS-1:0] y_end_i,
  input  wire logic [1:0]            line_style_i,
  output logic [COORD_BITS-1:0]      pixel_x_o,
  output logic [COORD_BITS-1:0]      pixel_y_o,
  output logic                       visible_o,
  output logic                       last_o
);

  // Line state.
  logic [ACC_BITS-1:0]   x_acc_q, x_acc_d;
  logic [ACC_BITS-1:0]   y_acc_q, y_acc_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [IDX_BITS-1:0]   total_q, total_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  style_e                style_q, style_d;
  logic [ACC_BITS-1:0]   x_step_q, x_step_d;
  logic [ACC_BITS-1:0]   y_step_q, y_step_d;

  // Divider state.
  logic [DIV_W-1:0]      xq_q, xq_d, yq_q, yq_d;
  logic [COORD_BITS-1:0] xr_q, xr_d, yr_q, yr_d;
  logic                  x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;

  // Output payload.
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic                  vis_q, vis_d, last_q, last_d;

  // Start-side arithmetic.
  logic [COORD_BITS-1:0] adx, ady, new_total;
  logic                  x_neg_in, y_neg_in;

  // Advance-side arithmetic.
  logic [ACC_BITS-1:0]   x_acc_adv, y_acc_adv;
  logic [IDX_BITS-1:0]   idx_next;
  logic [PHASE_BITS:0]   phase_inc;
  logic [PHASE_BITS-1:0] phase_next;
  logic                  vis_adv;

  // Divider iteration.
  logic [COORD_BITS:0]   x_trial, y_trial;
  logic                  x_ge, y_ge;
  logic [COORD_BITS:0]   x_diff, y_diff;

  // Control registers of the line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc_q <= '0;
      y_acc_q <= '0;
      idx_q   <= '0;
      total_q <= '0;
      phase_q <= '0;
      style_q <= STYLE_DASHED;
      cnt_q   <= '0;
    end else begin
      x_acc_q <= x_acc_d;
      y_acc_q <= y_acc_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      phase_q <= phase_d;
      style_q <= style_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers: increments, divider and output beat.
  always_ff @(posedge clk_i) begin
    x_step_q <= x_step_d;
    y_step_q <= y_step_d;
    xq_q     <= xq_d;
    yq_q     <= yq_d;
    xr_q     <= xr_d;
    yr_q     <= yr_d;
    x_neg_q  <= x_neg_d;
    y_neg_q  <= y_neg_d;
    px_q     <= px_d;
    py_q     <= py_d;
    vis_q    <= vis_d;
    last_q   <= last_d;
  end

  // Step count of a new line: the larger absolute difference.
  always_comb begin
    x_neg_in  = x_end_i < x_start_i;
    y_neg_in  = y_end_i < y_start_i;
    adx       = x_neg_in ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    ady       = y_neg_in ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    new_total = (adx >= ady) ? adx : ady;
  end

  // One DDA step: accumulators, index, dash phase and visibility.
  always_comb begin
    x_acc_adv  = x_acc_q + x_step_q;
    y_acc_adv  = y_acc_q + y_step_q;
    idx_next   = idx_q + IDX_BITS'(1);
    phase_inc  = {1'b0, phase_q} + (PHASE_BITS + 1)'(1);
    phase_next = (phase_inc >= (PHASE_BITS + 1)'(DASH_PERIOD))
                 ? '0 : phase_inc[PHASE_BITS-1:0];
    unique case (style_q)
      STYLE_DASHED: vis_adv = (phase_next != '0);
      STYLE_DOTTED: vis_adv = idx_next[0];
      default:      vis_adv = 1'b1;
    endcase
  end

  // One restoring division iteration on each axis.
  always_comb begin
    x_trial = {xr_q, xq_q[DIV_W-1]};
    y_trial = {yr_q, yq_q[DIV_W-1]};
    x_ge    = x_trial >= total_q;
    y_ge    = y_trial >= total_q;
    x_diff  = x_trial - total_q;
    y_diff  = y_trial - total_q;
  end

  // Status towards the controller.
  always_comb begin
    stat_o           = '0;
    stat_o.start_fin = (new_total == '0)
                       || (style_e'(line_style_i) == STYLE_START_ONLY);
    stat_o.adv_fin   = idx_next >= total_q;
    stat_o.div_done  = (cnt_q == CNT_BITS'(1));
  end

  // Next-state selection for the commands.
  always_comb begin
    x_acc_d  = x_acc_q;
    y_acc_d  = y_acc_q;
    idx_d    = idx_q;
    total_d  = total_q;
    phase_d  = phase_q;
    style_d  = style_q;
    cnt_d    = cnt_q;
    x_step_d = x_step_q;
    y_step_d = y_step_q;
    xq_d     = xq_q;
    yq_d     = yq_q;
    xr_d     = xr_q;
    yr_d     = yr_q;
    x_neg_d  = x_neg_q;
    y_neg_d  = y_neg_q;
    px_d     = px_q;
    py_d     = py_q;
    vis_d    = vis_q;
    last_d   = last_q;

    priority if (cmd_i.start) begin
      // New line: load the start point and set up both dividers.
      x_acc_d = {1'b0, x_start_i, FRAC_BITS'(0)};
      y_acc_d = {1'b0, y_start_i, FRAC_BITS'(0)};
      idx_d   = '0;
      phase_d = '0;
      total_d = {1'b0, new_total};
      style_d = style_e'(line_style_i);
      cnt_d   = CNT_BITS'(DIV_W);
      xq_d    = {adx, FRAC_BITS'(0)};
      yq_d    = {ady, FRAC_BITS'(0)};
      xr_d    = '0;
      yr_d    = '0;
      x_neg_d = x_neg_in;
      y_neg_d = y_neg_in;
      px_d    = x_start_i;
      py_d    = y_start_i;
      vis_d   = 1'b1;
      last_d  = stat_o.start_fin;
    end else if (cmd_i.advance) begin
      x_acc_d = x_acc_adv;
      y_acc_d = y_acc_adv;
      idx_d   = idx_next;
      phase_d = phase_next;
      px_d    = x_acc_adv[FRAC_BITS +: COORD_BITS];
      py_d    = y_acc_adv[FRAC_BITS +: COORD_BITS];
      vis_d   = vis_adv;
      last_d  = stat_o.adv_fin;
    end else if (cmd_i.idle_adv) begin
      // Nothing to draw: repeat the current point as hidden.
      px_d   = x_acc_q[FRAC_BITS +: COORD_BITS];
      py_d   = y_acc_q[FRAC_BITS +: COORD_BITS];
      vis_d  = 1'b0;
      last_d = 1'b1;
    end else if (cmd_i.div_run) begin
      xq_d  = {xq_q[DIV_W-2:0], x_ge};
      yq_d  = {yq_q[DIV_W-2:0], y_ge};
      xr_d  = x_ge ? x_diff[COORD_BITS-1:0] : x_trial[COORD_BITS-1:0];
      yr_d  = y_ge ? y_diff[COORD_BITS-1:0] : y_trial[COORD_BITS-1:0];
      cnt_d = cnt_q - CNT_BITS'(1);
    end else if (cmd_i.div_fix) begin
      // Signed increments in the accumulator format.
      x_step_d = x_neg_q ? (ACC_BITS'(0) - {1'b0, xq_q}) : {1'b0, xq_q};
      y_step_d = y_neg_q ? (ACC_BITS'(0) - {1'b0, yq_q}) : {1'b0, yq_q};
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;
  assign visible_o = vis_q;
  assign last_o    = last_q;

endmodule : dlr_dp
`default_nettype wire

FILE: src/dlr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_checker: port-level checks of the line rasteriser
// Watches both channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module dlr_checker
  import dlr_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  in_req_type_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic [COORD_BITS-1:0] pixel_x_i,
  input wire logic [COORD_BITS-1:0] pixel_y_i,
  input wire logic                  visible_i,
  input wire logic                  last_i
);

  // Every request beat gives a pixel beat in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("request beat gave no pixel beat");

  // The start pixel of a line is always drawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (req_e'(in_req_type_i) == REQ_START))
      |=> visible_i)
    else $error("start pixel is hidden");

  // A stalled pixel beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("pixel beat withdrawn while stalled");

  // A stalled pixel beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i)
      |=> ($stable(pixel_x_i) && $stable(pixel_y_i)
           && $stable(visible_i) && $stable(last_i)))
    else $error("pixel beat changed while stalled");

endmodule : dlr_checker

bind dda_line_rasterizer_styled dlr_checker u_dlr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_req_type_i (req_i.req_type),
  .out_valid_i   (pix_o.valid),
  .out_ready_i   (pix_o.ready),
  .pixel_x_i     (pix_o.pixel_x),
  .pixel_y_i     (pix_o.pixel_y),
  .visible_i     (pix_o.visible),
  .last_i        (pix_o.last)
);
`default_nettype wire
